FILE: rtl/core/min_heap_priority_queue_core_macros.svh
// assertion macros for the min-heap priority queue core
`ifndef MIN_HEAP_PRIORITY_QUEUE_CORE_MACROS_SVH
`define MIN_HEAP_PRIORITY_QUEUE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define MHPQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define MHPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MHPQ_ASSERT_IMPL(label, ante, cons)
`define MHPQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/core/mhpq_pkg.sv
// shared types and codes for the min-heap priority queue core
package mhpq_pkg;

    // operation selector on the request side
    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_EX_ROOT,
        S_EX_LAST,
        S_EX_TAKE,
        S_DN_LEFT,
        S_DN_RIGHT,
        S_DN_CMP,
        S_OUT
    } t_state;

endpackage

FILE: rtl/core/mhpq_ram.sv
// generic simple dual-port ram with registered read
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/min_heap_priority_queue_core.sv
// min-heap priority queue core, one request at a time through a shared compare unit and heap ram
// insert: append at the end, then climb through read and compare steps until the root or a parent no larger
// extract: read the root and the last entry, then sift the last entry down from the root through
// left read, right read and compare steps; the single ram read port sets this order of steps
// s_axis_tready returns the cycle after the result register loads: one request at a time
// i_rst_n (synchronous, active low) empties the queue; heap ram contents are not cleared
module min_heap_priority_queue_core
    import mhpq_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int VERTEX_BITS = 8,
    parameter int LENGTH_BITS = 16,
    localparam int EW         = 2 * VERTEX_BITS + LENGTH_BITS,
    localparam int DW         = ((EW + 7) / 8) * 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // request side
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [DW-1:0] s_axis_tdata,  // edge_source, edge_dest, edge_length, zero pad
    input  logic          s_axis_tuser,  // kind
    // result side
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [DW-1:0] m_axis_tdata,  // out_source, out_dest, out_length, zero pad
    output logic [2:0]    m_axis_tuser   // status[1:0], now_empty
);

    localparam int AW = $clog2(CAPACITY);       // ram address
    localparam int CW = $clog2(CAPACITY + 1);   // entry count and heap position

    `include "min_heap_priority_queue_core_macros.svh"

    // control state
    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid, n_out_valid;

    // working payload
    logic [CW-1:0] r_pos, n_pos;        // 1-based position of the hole
    logic [EW-1:0] r_item, n_item;      // entry being sifted
    logic [EW-1:0] r_left, n_left;      // left child during sift down
    logic          r_rc_ok, n_rc_ok;    // right child exists
    logic [EW-1:0] r_res, n_res;        // extracted entry
    t_status       r_status, n_status;
    logic [EW-1:0] r_out_data, n_out_data;
    t_status       r_out_status, n_out_status;
    logic          r_out_empty, n_out_empty;

    // heap ram, entry k lives at address k-1, entry packed {length, dest, source}
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [EW-1:0] ram_wr_data;
    logic [AW-1:0] ram_rd_addr;
    logic [EW-1:0] ram_rd_data;

    mhpq_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // keys of the shared compare unit
    logic [LENGTH_BITS-1:0] item_len, rd_len, left_len;
    assign item_len = r_item[EW-1 -: LENGTH_BITS];
    assign rd_len   = ram_rd_data[EW-1 -: LENGTH_BITS];
    assign left_len = r_left[EW-1 -: LENGTH_BITS];

    // tree navigation
    logic [CW:0]   lc, rc;
    logic [CW-1:0] parent;
    assign lc     = {r_pos, 1'b0};
    assign rc     = {r_pos, 1'b1};
    assign parent = r_pos >> 1;

    logic left_better, right_better;

    assign s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_item       = r_item;
        n_left       = r_left;
        n_rc_ok      = r_rc_ok;
        n_res        = r_res;
        n_status     = r_status;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_empty  = r_out_empty;
        n_out_valid  = r_out_valid & ~m_axis_tready;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = AW'(r_pos - CW'(1));
        ram_wr_data  = r_item;
        ram_rd_addr  = '0;
        left_better  = 1'b0;
        right_better = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_res    = '0;
                    n_status = ST_OK;
                    if (s_axis_tuser == KIND_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_OUT;
                        end else begin
                            // append at the end, then climb
                            n_count = r_count + CW'(1);
                            n_pos   = r_count + CW'(1);
                            n_item  = s_axis_tdata[EW-1:0];
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_OUT;
                        end else begin
                            n_state = S_EX_ROOT;
                        end
                    end
                end
            end

            S_UP_RD: begin
                if (r_pos == CW'(1)) begin
                    // reached the root
                    ram_wr_en = 1'b1;
                    n_state   = S_OUT;
                end else begin
                    ram_rd_addr = AW'(parent - CW'(1));
                    n_state     = S_UP_CMP;
                end
            end

            S_UP_CMP: begin
                ram_wr_en = 1'b1;
                if (item_len < rd_len) begin
                    // parent moves down into the hole
                    ram_wr_data = ram_rd_data;
                    n_pos       = parent;
                    n_state     = S_UP_RD;
                end else begin
                    n_state = S_OUT;
                end
            end

            S_EX_ROOT: begin
                ram_rd_addr = '0;
                n_state     = S_EX_LAST;
            end

            S_EX_LAST: begin
                ram_rd_addr = AW'(r_count - CW'(1));
                n_res       = ram_rd_data;
                n_state     = S_EX_TAKE;
            end

            S_EX_TAKE: begin
                // last entry becomes the item sifted down from the root
                n_item  = ram_rd_data;
                n_count = r_count - CW'(1);
                n_pos   = CW'(1);
                n_state = (r_count == CW'(1)) ? S_OUT : S_DN_LEFT;
            end

            S_DN_LEFT: begin
                if (lc > {1'b0, r_count}) begin
                    // leaf, item settles here
                    ram_wr_en = 1'b1;
                    n_state   = S_OUT;
                end else begin
                    ram_rd_addr = AW'(lc - (CW+1)'(1));
                    n_state     = S_DN_RIGHT;
                end
            end

            S_DN_RIGHT: begin
                n_left      = ram_rd_data;
                n_rc_ok     = (rc <= {1'b0, r_count});
                ram_rd_addr = AW'(rc - (CW+1)'(1));
                n_state     = S_DN_CMP;
            end

            S_DN_CMP: begin
                // left wins ties, each child must be strictly smaller to move
                left_better  = left_len < item_len;
                right_better = r_rc_ok &&
                               (rd_len < (left_better ? left_len : item_len));
                ram_wr_en    = 1'b1;
                if (right_better) begin
                    ram_wr_data = ram_rd_data;
                    n_pos       = CW'(rc);
                    n_state     = S_DN_LEFT;
                end else if (left_better) begin
                    ram_wr_data = r_left;
                    n_pos       = CW'(lc);
                    n_state     = S_DN_LEFT;
                end else begin
                    n_state = S_OUT;
                end
            end

            S_OUT: begin
                // hand the result to the output register once it is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = r_res;
                    n_out_status = r_status;
                    n_out_empty  = (r_count == '0);
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_item       <= n_item;
        r_left       <= n_left;
        r_rc_ok      <= n_rc_ok;
        r_res        <= n_res;
        r_status     <= n_status;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_empty  <= n_out_empty;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = DW'(r_out_data);
    assign m_axis_tuser  = {r_out_empty, r_out_status};

    // checks
    `MHPQ_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CW'(CAPACITY))
    `MHPQ_ASSERT_NEXT(a_busy_after_request, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `MHPQ_ASSERT_NEXT(a_insert_grows,
        s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_INSERT &&
        r_count != CW'(CAPACITY),
        r_count == $past(r_count) + CW'(1))
    `MHPQ_ASSERT_IMPL(a_empty_flag,
        m_axis_tvalid && m_axis_tuser[1:0] == ST_EMPTY, m_axis_tuser[2])

endmodule
